/* rtl/core/vce_pkg.sv */
// shared types and constants of the value dictionary encoder
// request, response, cell chain and cell command structs
// no dependencies
`default_nettype none

package vce_pkg;

  localparam int unsigned DefaultEntries   = 16;
  localparam int unsigned DefaultWordBytes = 4;
  localparam int unsigned DefaultPeers     = 16;

  localparam int unsigned DataW     = 32;
  localparam int unsigned DestW     = 4;
  localparam int unsigned ValIdxW   = 8;
  localparam int unsigned CountW    = 8;
  localparam int unsigned EntryIdxW = 8;

  localparam logic [CountW-1:0] CountMax = 8'hFF;
  localparam logic [CountW-1:0] SatReset = 8'd16;

  typedef enum logic {
    REQ_LOOKUP  = 1'b0,
    REQ_INSTALL = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    OP_NONE        = 2'd0,
    OP_BUMP        = 2'd1,
    OP_INSTALL_NEW = 2'd2,
    OP_MARK        = 2'd3
  } cell_op_e;

  typedef struct packed {
    req_type_e            req_type;
    logic [DataW-1:0]     value_word;
    logic [DestW-1:0]     dest;
    logic [ValIdxW-1:0]   code_idx;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic                 value_found;
    logic [ValIdxW-1:0]   hit_code;
  } rsp_t;

  typedef struct packed {
    logic                 tok;
    logic                 found;
    logic [EntryIdxW-1:0] match_idx;
    logic                 match_mark;
    logic [CountW-1:0]    match_cnt;
    logic                 inv_found;
    logic [EntryIdxW-1:0] inv_idx;
    logic [CountW-1:0]    min_cnt;
    logic [EntryIdxW-1:0] min_idx;
  } chain_t;

  typedef struct packed {
    cell_op_e             op;
    logic [EntryIdxW-1:0] target;
    logic                 halve;
    logic [CountW-1:0]    new_cnt;
    logic [DataW-1:0]     word;
    logic [DestW-1:0]     dest;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/vce_cell.sv */
// one dictionary entry: word, use count and destination marks
// forwards the search token with running match, empty and minimum results
// depends on vce_pkg
`default_nettype none

module vce_cell #(
  parameter int unsigned CELL_IDX  = 0,
  parameter int unsigned WORD_W    = 32,
  parameter int unsigned NUM_PEERS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vce_pkg::chain_t chain_i,
  output vce_pkg::chain_t chain_o,
  input  vce_pkg::cmd_t   cmd_i
);
  import vce_pkg::*;

  localparam logic [EntryIdxW-1:0] MyIdx = EntryIdxW'(CELL_IDX);

  logic                 valid_q, valid_d;
  logic [WORD_W-1:0]    word_q, word_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic [NUM_PEERS-1:0] marks_q, marks_d;
  chain_t               chain_q, chain_d;

  logic                 match;
  logic                 target;
  logic [NUM_PEERS-1:0] mark_sh;
  logic [NUM_PEERS-1:0] dest_bit;

  assign match    = valid_q && (word_q == cmd_i.word[WORD_W-1:0]);
  assign target   = (cmd_i.target == MyIdx);
  assign mark_sh  = marks_q >> cmd_i.dest;
  assign dest_bit = NUM_PEERS'(1) << cmd_i.dest;

  always_comb begin
    chain_d = chain_i;
    if (!chain_i.found && match) begin
      chain_d.found      = 1'b1;
      chain_d.match_idx  = MyIdx;
      chain_d.match_mark = mark_sh[0];
      chain_d.match_cnt  = cnt_q;
    end
    if (!chain_i.inv_found && !valid_q) begin
      chain_d.inv_found = 1'b1;
      chain_d.inv_idx   = MyIdx;
    end
    if (cnt_q < chain_i.min_cnt) begin
      chain_d.min_cnt = cnt_q;
      chain_d.min_idx = MyIdx;
    end
  end

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    cnt_d   = cnt_q;
    marks_d = marks_q;
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_BUMP: begin
        if (target) begin
          cnt_d = cmd_i.new_cnt;
        end
        if (cmd_i.halve) begin
          cnt_d = cnt_d >> 1;
        end
      end
      OP_INSTALL_NEW: begin
        if (target) begin
          valid_d = 1'b1;
          word_d  = cmd_i.word[WORD_W-1:0];
          cnt_d   = 8'd1;
          marks_d = dest_bit;
        end
      end
      OP_MARK: begin
        if (target) begin
          marks_d = marks_q | dest_bit;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      marks_q <= '0;
      chain_q <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      marks_q <= marks_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign chain_o = chain_q;

`ifndef SYNTHESIS
  a_valid_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> valid_q)
    else $error("entry valid bit dropped");

  a_install_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_INSTALL_NEW) && target |=> valid_q && (cnt_q == 8'd1))
    else $error("install did not load entry");

  a_halve_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_BUMP) && cmd_i.halve && !target |=> cnt_q == ($past(cnt_q) >> 1))
    else $error("count not halved");

  a_token_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_i.tok |=> chain_o.tok)
    else $error("search token lost in cell");
`endif

endmodule

`default_nettype wire

/* rtl/core/value_cam_lfu_encoder.sv */
// top level of the value dictionary encoder: request sequencer, cell chain
// and destination index memory
// depends on vce_pkg and vce_cell
//
// usage:
//   request channel in_valid_i / in_stall_o carries a vce_pkg::req_t; a lookup
//   (req_type 0) or an install (req_type 1) is taken when valid is high and
//   stall is low. one request is processed at a time.
//   response channel out_valid_o / out_stall_i carries a vce_pkg::rsp_t, one
//   response per request, in request order.
//   cfg_valid_i / cfg_ready_o writes lfu_saturation from cfg_data_i; ready is
//   always high, write only while no request is pending.
//   after accept, the search token starts from a register and walks the cell
//   chain one entry per cycle; as it leaves the chain, the entries are updated
//   and the index memory is read in the same cycle, then the output is loaded.
//   a new request is taken only after the response of the last one is loaded.
//   a stalled response waits in the output register; a new request can still
//   be taken and searched, and its response waits until the register frees.
//   reset clears all entries, counts and marks at once and sets saturation 16;
//   the index memory is not cleared, its data is used only behind a set mark.
`default_nettype none

module value_cam_lfu_encoder #(
  parameter int unsigned NUM_ENTRIES = vce_pkg::DefaultEntries,
  parameter int unsigned WORD_BYTES  = vce_pkg::DefaultWordBytes,
  parameter int unsigned NUM_PEERS   = vce_pkg::DefaultPeers
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  vce_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output vce_pkg::rsp_t out_rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [7:0]    cfg_data_i
);
  import vce_pkg::*;

  localparam int unsigned WordW  = (WORD_BYTES * 8 > DataW) ? DataW : WORD_BYTES * 8;
  localparam int unsigned IdxW   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned PeerW  = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam int unsigned AddrW  = IdxW + PeerW;
  localparam int unsigned MemDep = 2 ** AddrW;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic              start_q;
  req_t              req_q;
  logic [CountW-1:0] sat_q;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_rsp_q;
  logic              hit_q, found_q;
  logic [ValIdxW-1:0] rdata_q;
  logic [ValIdxW-1:0] mem_q [MemDep];

  chain_t            links [NUM_ENTRIES+1];
  chain_t            head;
  chain_t            tail;
  cmd_t              cmd;

  logic              accept;
  logic              commit;
  logic              dest_ok;
  logic              hit_c;
  logic              out_load;
  logic [CountW-1:0] bump_cnt;
  logic [EntryIdxW-1:0] victim;
  logic              mem_we;
  logic [AddrW-1:0]  waddr, raddr;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    head         = '0;
    head.tok     = start_q;
    head.min_cnt = CountMax;
  end

  assign links[0] = head;

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    vce_cell #(
      .CELL_IDX  (i),
      .WORD_W    (WordW),
      .NUM_PEERS (NUM_PEERS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .chain_i (links[i]),
      .chain_o (links[i+1]),
      .cmd_i   (cmd)
    );
  end

  assign tail     = links[NUM_ENTRIES];
  assign commit   = (state_q == ST_SEARCH) && tail.tok;
  assign dest_ok  = (32'(req_q.dest) < NUM_PEERS);
  assign bump_cnt = (tail.match_cnt == CountMax) ? CountMax : tail.match_cnt + 8'd1;
  assign victim   = tail.inv_found ? tail.inv_idx : tail.min_idx;
  assign hit_c    = (req_q.req_type == REQ_LOOKUP) && tail.found && dest_ok
                    && tail.match_mark;
  assign raddr    = {tail.match_idx[IdxW-1:0], PeerW'(req_q.dest)};

  always_comb begin
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.word    = req_q.value_word;
    cmd.dest    = req_q.dest;
    cmd.new_cnt = bump_cnt;
    cmd.halve   = (bump_cnt >= sat_q);
    mem_we      = 1'b0;
    if (commit) begin
      if (req_q.req_type == REQ_LOOKUP) begin
        if (tail.found) begin
          cmd.op     = OP_BUMP;
          cmd.target = tail.match_idx;
        end
      end else if (dest_ok) begin
        mem_we = 1'b1;
        if (tail.found) begin
          cmd.op     = OP_MARK;
          cmd.target = tail.match_idx;
        end else begin
          cmd.op     = OP_INSTALL_NEW;
          cmd.target = victim;
        end
      end
    end
  end

  assign waddr    = {cmd.target[IdxW-1:0], PeerW'(req_q.dest)};
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tail.tok) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      sat_q       <= SatReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= accept;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        sat_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (commit) begin
      hit_q   <= hit_c;
      found_q <= tail.found;
    end
    if (out_load) begin
      out_rsp_q.hit         <= hit_q;
      out_rsp_q.value_found <= found_q;
      out_rsp_q.hit_code    <= hit_q ? rdata_q : '0;
    end
  end

  // destination index memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= req_q.code_idx;
    end
    if (commit) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> (state_q == ST_SEARCH) && start_q)
    else $error("accepted request did not start search");

  a_token_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) && tail.tok |=> state_q == ST_DONE)
    else $error("search end not seen");

  a_hit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_rsp_o.hit || out_rsp_o.value_found)
    else $error("hit without stored word");
`endif

endmodule

`default_nettype wire
